// ===== rtl/srle_pkg.sv =====
package srle_pkg;

	// Run counter width; the thousands split below holds for 11 to 20 bits.
	localparam int RUN_WIDTH = 20;
	localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;

	localparam logic [15:0] LEVEL_OFFSET = 16'h8000;
	localparam logic [31:0] LONG_FLAG    = 32'h0400_0000;
	localparam logic [31:0] LOOP_FLAG    = 32'h1000_0000;
	localparam logic [15:0] BASE_ADDR    = 16'h9f20;
	localparam logic [15:0] COUNT_MAX    = 16'hffff;
	localparam logic [9:0]  TH_MAX       = 10'h3ff;
	localparam int TICKS_PER_LONG = 1000;

	// len / 1000 = ((len >> 3) * RECIP) >> RECIP_SHIFT, exact for len < 2^20
	localparam logic [16:0] RECIP = 17'd67109;
	localparam int RECIP_SHIFT = 23;
	localparam int PROD_W = RUN_WIDTH + 14;
	localparam int Q_W = PROD_W - RECIP_SHIFT;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [1:0] {
		CFG_STEP_THRESHOLD = 2'd0,
		CFG_REPEAT_COUNT   = 2'd1,
		CFG_CHANNEL_SELECT = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [15:0] step_threshold;
		logic [11:0] repeat_count;
		logic [3:0]  channel_select;
	} cfg_t;

	// One run split into an optional long vector and an optional remainder vector.
	typedef struct packed {
		logic [15:0] value;
		logic        long_en;
		logic [9:0]  th;
		logic        rem_en;
		logic [9:0]  rem1;
	} srle_run_t;

	typedef struct packed {
		srle_run_t run_a;  // run closed by a step
		srle_run_t run_b;  // run flushed by the final sample
		logic      fin;
	} srle_job_t;

	function automatic srle_run_t make_run(input logic [RUN_WIDTH-1:0] len,
			input logic [Q_W-1:0] q, input logic [15:0] value);
		srle_run_t r;
		logic [RUN_WIDTH-1:0] rest;
		logic [Q_W+10:0] q_ext;
		r.value = value;
		r.long_en = len > RUN_WIDTH'(TICKS_PER_LONG);
		q_ext = (Q_W+11)'(q);
		rest = r.long_en ? len - RUN_WIDTH'(q_ext * (Q_W+11)'(TICKS_PER_LONG)) : len;
		r.th = (q_ext > (Q_W+11)'(1024)) ? TH_MAX : 10'(q_ext - (Q_W+11)'(1));
		r.rem_en = rest != '0;
		r.rem1 = 10'(rest - RUN_WIDTH'(1));
		return r;
	endfunction

endpackage

// ===== rtl/srle_front.sv =====
module srle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         level,
	input  logic                fin,
	input  logic [15:0]         step_threshold,
	input  logic                full,
	output logic                push,
	output srle_pkg::srle_job_t push_job
);

	logic [15:0] held_q;
	logic [srle_pkg::RUN_WIDTH-1:0] run_q;

	logic signed [16:0] diff;
	logic [16:0] mag;
	logic step, advance, accept;
	logic [srle_pkg::RUN_WIDTH-1:0] run_inc, len_b_new;
	logic [15:0] lev_b_new;

	logic valid_s1, fin_s1;
	logic [srle_pkg::RUN_WIDTH-1:0] len_a_s1, len_b_s1;
	logic [15:0] val_a_s1, val_b_s1;

	logic valid_s2, fin_s2;
	logic [srle_pkg::RUN_WIDTH-1:0] len_a_s2, len_b_s2;
	logic [15:0] val_a_s2, val_b_s2;
	logic [srle_pkg::Q_W-1:0] q_a_s2, q_b_s2;
	logic [srle_pkg::PROD_W-1:0] prod_a, prod_b;

	logic valid_s3;
	srle_pkg::srle_job_t job_s3, job_next;
	logic job_any;

	always_comb begin
		diff = 17'(signed'(level)) - 17'(signed'(held_q));
		mag = diff[16] ? 17'(-diff) : 17'(diff);
		step = mag > {1'b0, step_threshold};
		run_inc = (run_q != srle_pkg::RUN_MAX) ? run_q + 1'b1 : run_q;
		len_b_new = step ? srle_pkg::RUN_WIDTH'(1) : run_inc;
		lev_b_new = step ? level : held_q;
		advance = !(valid_s3 && full);
		accept = s_tvalid && advance;
	end

	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			run_q <= '0;
		end else if (accept) begin
			if (fin) begin
				held_q <= '0;
				run_q <= '0;
			end else begin
				held_q <= lev_b_new;
				run_q <= len_b_new;
			end
		end
	end

	// Thousands quotient by reciprocal multiply
	always_comb begin
		prod_a = srle_pkg::PROD_W'(len_a_s1 >> 3) * srle_pkg::PROD_W'(srle_pkg::RECIP);
		prod_b = srle_pkg::PROD_W'(len_b_s1 >> 3) * srle_pkg::PROD_W'(srle_pkg::RECIP);
	end

	always_comb begin
		job_next.run_a = srle_pkg::make_run(len_a_s2, q_a_s2, val_a_s2);
		job_next.run_b = srle_pkg::make_run(len_b_s2, q_b_s2, val_b_s2);
		job_next.fin = fin_s2;
		job_any = fin_s2 || job_next.run_a.long_en || job_next.run_a.rem_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && job_any;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			len_a_s1 <= step ? run_q : '0;
			val_a_s1 <= held_q ^ srle_pkg::LEVEL_OFFSET;
			len_b_s1 <= fin ? len_b_new : '0;
			val_b_s1 <= lev_b_new ^ srle_pkg::LEVEL_OFFSET;
			fin_s1 <= fin;

			len_a_s2 <= len_a_s1;
			len_b_s2 <= len_b_s1;
			val_a_s2 <= val_a_s1;
			val_b_s2 <= val_b_s1;
			q_a_s2 <= prod_a[srle_pkg::PROD_W-1:srle_pkg::RECIP_SHIFT];
			q_b_s2 <= prod_b[srle_pkg::PROD_W-1:srle_pkg::RECIP_SHIFT];
			fin_s2 <= fin_s1;

			job_s3 <= job_next;
		end
	end

	assign push = valid_s3 && !full;
	assign push_job = job_s3;

endmodule

// ===== rtl/srle_queue.sv =====
module srle_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  srle_pkg::srle_job_t push_job,
	input  logic                pop,
	output srle_pkg::srle_job_t head,
	output logic                full,
	output logic                empty
);

	srle_pkg::srle_job_t mem_q [srle_pkg::QDEPTH];
	logic [srle_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [srle_pkg::QPTR_W:0] count_q;

	assign full = count_q == (srle_pkg::QPTR_W+1)'(srle_pkg::QDEPTH);
	assign empty = count_q == '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("job popped from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (srle_pkg::QPTR_W+1)'(srle_pkg::QDEPTH))
		else $error("queue count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/srle_back.sv =====
module srle_back (
	input  logic                clk,
	input  logic                arst_n,
	input  srle_pkg::cfg_t      cfg,
	input  srle_pkg::srle_job_t head,
	input  logic                empty,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         vector_word,
	output logic [15:0]         register_address,
	output logic                end_of_burst
);

	// mask bits: run_a long, run_a rest, run_b long, run_b rest, loop
	srle_pkg::srle_job_t job_q;
	logic [4:0] mask_q, sel, next_mask, head_mask;
	logic [15:0] count_q;
	logic m_tvalid_q, eob_q;
	logic [31:0] word_q;
	logic [15:0] addr_q;

	logic out_free, emit, last;
	logic [31:0] word;

	always_comb begin
		out_free = !m_tvalid_q || m_tready;
		sel = mask_q & (~mask_q + 5'd1);
		next_mask = mask_q & ~sel;
		last = next_mask == '0;
		emit = out_free && (mask_q != '0);
		pop = !empty && ((mask_q == '0) || (emit && last));
		head_mask = {head.fin && (cfg.repeat_count > 12'd1),
			head.run_b.rem_en, head.run_b.long_en,
			head.run_a.rem_en, head.run_a.long_en};
		case (sel)
			5'b00001: word = srle_pkg::LONG_FLAG | {6'd0, job_q.run_a.th, job_q.run_a.value};
			5'b00010: word = {6'd0, job_q.run_a.rem1, job_q.run_a.value};
			5'b00100: word = srle_pkg::LONG_FLAG | {6'd0, job_q.run_b.th, job_q.run_b.value};
			5'b01000: word = {6'd0, job_q.run_b.rem1, job_q.run_b.value};
			default:  word = srle_pkg::LOOP_FLAG | {4'd0, cfg.repeat_count, count_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop)
				mask_q <= head_mask;
			else if (emit)
				mask_q <= next_mask;
			if (emit) begin
				m_tvalid_q <= 1'b1;
				if (last && job_q.fin)
					count_q <= '0;
				else if (!sel[4] && count_q != srle_pkg::COUNT_MAX)
					count_q <= count_q + 1'b1;
			end else if (out_free) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
		if (emit) begin
			word_q <= word;
			addr_q <= srle_pkg::BASE_ADDR + {10'd0, cfg.channel_select, 2'b00};
			eob_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign vector_word = word_q;
	assign register_address = addr_q;
	assign end_of_burst = eob_q;

endmodule

// ===== rtl/stimulus_run_length_encoder_unit.sv =====
// Stimulus run-length encoder: takes one signed waveform sample per
// transaction on the slave stream and writes generator memory vectors on the
// master stream. Samples are accepted one per cycle while s_tready is high;
// the front updates the held level and run counter at acceptance, splits each
// run that ends into thousands and remainder through a three-stage pipeline
// (reciprocal multiply, then remainder), and pushes a job into a four-entry
// queue. The back drains that queue one vector per cycle unless m_tready
// stalls it, so a sample that ends a run yields up to two vectors and a final
// sample up to five; sustained throughput is one sample per cycle as long as
// the average vector rate stays at or below one per cycle, and s_tready drops
// only when the queue is full. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; nothing enforces it.
module stimulus_run_length_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_level
	input  logic        s_tlast,   // final_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] vector_word, [47:32] register_address
	output logic        m_tlast,   // end_of_burst
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	srle_pkg::cfg_t cfg_q;

	logic push, pop, full, empty;
	srle_pkg::srle_job_t push_job, head;
	logic [31:0] vector_word;
	logic [15:0] register_address;

	// Register writes; unknown indexes drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_threshold <= '0;
			cfg_q.repeat_count <= 12'd1;
			cfg_q.channel_select <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srle_pkg::CFG_STEP_THRESHOLD: cfg_q.step_threshold <= cfg_wdata;
				srle_pkg::CFG_REPEAT_COUNT:   cfg_q.repeat_count <= cfg_wdata[11:0];
				srle_pkg::CFG_CHANNEL_SELECT: cfg_q.channel_select <= cfg_wdata[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Front: classify each sample against the held level, queue run jobs.
	srle_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.level          (s_tdata),
		.fin            (s_tlast),
		.step_threshold (cfg_q.step_threshold),
		.full           (full),
		.push           (push),
		.push_job       (push_job)
	);

	// Queue: decouple sample intake from vector output.
	srle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	// Back: emit one vector per cycle unless stalled, count vectors, append loop vector.
	srle_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.head             (head),
		.empty            (empty),
		.pop              (pop),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.vector_word      (vector_word),
		.register_address (register_address),
		.end_of_burst     (m_tlast)
	);

	assign m_tdata = {register_address, vector_word};

endmodule
